[src/k_best_descriptor_matcher_core_assert.svh]
// assertion helpers for the matcher core
`ifndef K_BEST_DESCRIPTOR_MATCHER_CORE_ASSERT_SVH
`define K_BEST_DESCRIPTOR_MATCHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define KBDM_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// property that must hold in the cycle after a trigger
`define KBDM_ASSERT_NEXT(lbl, ck, rn, trig, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (prop)) else $error(msg);
`else
`define KBDM_ASSERT(lbl, ck, rn, prop, msg)
`define KBDM_ASSERT_NEXT(lbl, ck, rn, trig, prop, msg)
`endif
`endif

[src/kbdm_pkg.sv]
package kbdm_pkg;

	// sizes of the stores and the best list
	localparam int MAX_REF_ROWS = 256;
	localparam int MAX_DIMS     = 128;
	localparam int MAX_BEST     = 8;

	// input fields
	localparam int FUNC_W = 2;
	localparam int ROW_W  = 8;
	localparam int DIM_W  = 7;
	localparam int VAL_W  = 16;
	localparam int CNT_W  = 9;

	localparam int IN_ROW_LSB = 0;
	localparam int IN_DIM_LSB = IN_ROW_LSB + ROW_W;
	localparam int IN_VAL_LSB = IN_DIM_LSB + DIM_W;
	localparam int IN_CNT_LSB = IN_VAL_LSB + VAL_W;
	localparam int IN_BITS    = IN_CNT_LSB + CNT_W;
	localparam int S_DATA_W   = ((IN_BITS + 7) / 8) * 8;

	// result fields
	localparam int RANK_W   = 3;
	localparam int DIST_W   = 20;
	localparam int OUT_BITS = RANK_W + ROW_W + DIST_W;
	localparam int M_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int M_PAD_W  = M_DATA_W - OUT_BITS;

	// configuration registers
	localparam int BC_W      = 4;
	localparam int DU_W      = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_BEST_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 1'b1;
	localparam logic [BC_W-1:0] BEST_COUNT_RST  = 4'd4;
	localparam logic [DU_W-1:0] DIMS_IN_USE_RST = 8'd128;

	// item kinds
	localparam logic [FUNC_W-1:0] FUNC_LOAD_REF = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_QRY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RUN      = 2'd2;

	// derived datapath widths
	localparam int REF_AW     = ROW_W + DIM_W;
	localparam int REF_DEPTH  = MAX_REF_ROWS * MAX_DIMS;
	localparam int DIMS_CNT_W = $clog2(MAX_DIMS + 1);
	localparam int BEST_IW    = $clog2(MAX_BEST);
	localparam int DIFF_W     = VAL_W + 1;
	localparam int SQ_W       = 2 * VAL_W;
	localparam int ACC_W      = 2 * DIST_W;
	localparam int REM_W      = DIST_W + 3;
	localparam int SQRT_STEPS = DIST_W;
	localparam int SQ_CNT_W   = $clog2(SQRT_STEPS);

endpackage

[src/kbdm_ram.sv]
module kbdm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/k_best_descriptor_matcher_core.sv]
// loads: one per cycle while idle, written into the reference or query RAM at the accepting edge
// run: rows, dims and n are clamped
// per row: one element per cycle into a square-and-add path, a bit-pair square root
//   and a one-slot-per-cycle insertion pass; results then one per cycle while m_tready is high
// a run item waits in the start state until the previous results are all transferred
// arst_n clears control, best_count to 4 and dims_in_use to 128; RAM contents stay undefined
`include "k_best_descriptor_matcher_core_assert.svh"

module k_best_descriptor_matcher_core
	import kbdm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // row, dim, value, ref_count
	input  logic [FUNC_W-1:0]    s_tuser,   // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // rank, match_index, distance, zero pad
	output logic                 m_tuser,   // found
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_START  = 5'b00010,
		ST_ISSUE  = 5'b00100,
		ST_SQRT   = 5'b01000,
		ST_INSERT = 5'b10000
	} state_t;

	state_t state_q;

	logic [BC_W-1:0]       best_count_q;
	logic [DU_W-1:0]       dims_in_use_q;
	logic [CNT_W-1:0]      count_q;
	logic [DIMS_CNT_W-1:0] dims_q;
	logic [DIMS_CNT_W-1:0] d_q;
	logic [ROW_W-1:0]      row_q;
	logic [BEST_IW-1:0]    nm1_q;
	logic [BEST_IW-1:0]    k_q;
	logic [BEST_IW-1:0]    emit_k_q;
	logic                  out_busy_q;

	logic                     v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0] diff_s2;
	logic [SQ_W-1:0]          sq_s3;
	logic [ACC_W-1:0]         acc_q;

	logic [ACC_W-1:0]    sq_x_q;
	logic [REM_W-1:0]    sq_rem_q;
	logic [DIST_W-1:0]   sq_root_q;
	logic [SQ_CNT_W-1:0] sq_cnt_q;

	logic [DIST_W-1:0]   cd_q;
	logic [ROW_W-1:0]    cr_q;
	logic                cv_q;
	logic [DIST_W-1:0]   best_dist_q [MAX_BEST];
	logic [ROW_W-1:0]    best_row_q  [MAX_BEST];
	logic [MAX_BEST-1:0] best_valid_q;

	logic [FUNC_W-1:0] in_func;
	logic [ROW_W-1:0]  in_row;
	logic [DIM_W-1:0]  in_dim;
	logic [VAL_W-1:0]  in_value;
	logic [CNT_W-1:0]  in_count;
	logic              in_xfer;
	logic              ref_we, qry_we;

	logic [VAL_W-1:0]           q_rd, r_rd;
	logic                       issue_fire;
	logic                       drained;
	logic signed [2*DIFF_W-1:0] sq_prod;

	logic [BEST_IW-1:0]    nm1_d;
	logic [DIMS_CNT_W-1:0] dims_sat;
	logic [CNT_W-1:0]      count_sat;
	logic                  row_last;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              root_bit;
	logic [REM_W-1:0]  rem_nxt;
	logic [DIST_W-1:0] root_nxt;

	logic swap;
	logic sel_valid;
	logic scanning;
	logic out_xfer;

	// input unpacking
	assign in_func  = s_tuser;
	assign in_row   = s_tdata[IN_ROW_LSB +: ROW_W];
	assign in_dim   = s_tdata[IN_DIM_LSB +: DIM_W];
	assign in_value = s_tdata[IN_VAL_LSB +: VAL_W];
	assign in_count = s_tdata[IN_CNT_LSB +: CNT_W];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// loads go straight into the RAMs at the accepting edge
	assign ref_we = in_xfer && (in_func == FUNC_LOAD_REF)
		&& (CNT_W'(in_row) < CNT_W'(MAX_REF_ROWS))
		&& (DIMS_CNT_W'(in_dim) < DIMS_CNT_W'(MAX_DIMS));
	assign qry_we = in_xfer && (in_func == FUNC_LOAD_QRY)
		&& (DIMS_CNT_W'(in_dim) < DIMS_CNT_W'(MAX_DIMS));

	// element reads while scanning a row
	assign issue_fire = (state_q == ST_ISSUE) && (d_q != dims_q);
	assign drained    = !issue_fire && !v_s1 && !v_s2 && !v_s3;

	kbdm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (REF_DEPTH)
	) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr ({in_row, in_dim}),
		.wdata (in_value),
		.re    (issue_fire),
		.raddr ({row_q, d_q[DIM_W-1:0]}),
		.rdata (r_rd)
	);

	kbdm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_DIMS)
	) u_qry_ram (
		.clk   (clk),
		.we    (qry_we),
		.waddr (in_dim),
		.wdata (in_value),
		.re    (issue_fire),
		.raddr (d_q[DIM_W-1:0]),
		.rdata (q_rd)
	);

	// difference and square stages
	assign sq_prod = diff_s2 * diff_s2;

	always_ff @(posedge clk) begin
		diff_s2 <= $signed({q_rd[VAL_W-1], q_rd}) - $signed({r_rd[VAL_W-1], r_rd});
		sq_s3   <= sq_prod[SQ_W-1:0];
	end

	// clamped run settings
	always_comb begin
		if (best_count_q == '0) begin
			nm1_d = '0;
		end else if (best_count_q > BC_W'(MAX_BEST)) begin
			nm1_d = BEST_IW'(MAX_BEST - 1);
		end else begin
			nm1_d = BEST_IW'(best_count_q - BC_W'(1));
		end
		dims_sat  = (dims_in_use_q > DU_W'(MAX_DIMS)) ? DIMS_CNT_W'(MAX_DIMS)
			: DIMS_CNT_W'(dims_in_use_q);
		count_sat = (in_count > CNT_W'(MAX_REF_ROWS)) ? CNT_W'(MAX_REF_ROWS) : in_count;
		row_last  = (CNT_W'(row_q) == count_q - CNT_W'(1));
	end

	// one bit-pair step of the square root
	always_comb begin
		rem_sh   = {sq_rem_q[REM_W-3:0], sq_x_q[ACC_W-1 -: 2]};
		trial    = {1'b0, sq_root_q, 2'b01};
		root_bit = (rem_sh >= trial);
		rem_nxt  = root_bit ? (rem_sh - trial) : rem_sh;
		root_nxt = {sq_root_q[DIST_W-2:0], root_bit};
	end

	// insertion compare against the current slot
	assign swap = cv_q && (!best_valid_q[k_q] || (cd_q < best_dist_q[k_q]));

	// configuration, sequencer and result drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			best_count_q  <= BEST_COUNT_RST;
			dims_in_use_q <= DIMS_IN_USE_RST;
			count_q       <= '0;
			dims_q        <= '0;
			d_q           <= '0;
			row_q         <= '0;
			nm1_q         <= '0;
			k_q           <= '0;
			emit_k_q      <= '0;
			out_busy_q    <= 1'b0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			acc_q         <= '0;
			sq_x_q        <= '0;
			sq_rem_q      <= '0;
			sq_root_q     <= '0;
			sq_cnt_q      <= '0;
			cd_q          <= '0;
			cr_q          <= '0;
			cv_q          <= 1'b0;
			best_valid_q  <= '0;
			best_dist_q   <= '{default: '0};
			best_row_q    <= '{default: '0};
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BEST_COUNT:  best_count_q  <= cfg_wdata[BC_W-1:0];
					CFG_DIMS_IN_USE: dims_in_use_q <= cfg_wdata[DU_W-1:0];
				endcase
			end

			// result drain, one rank per transfer
			if (m_tvalid && m_tready) begin
				if (m_tlast) begin
					out_busy_q <= 1'b0;
				end else begin
					emit_k_q <= emit_k_q + BEST_IW'(1);
				end
			end

			v_s1 <= issue_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (in_func == FUNC_RUN)) begin
						count_q <= count_sat;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (!out_busy_q) begin
						best_valid_q <= '0;
						nm1_q        <= nm1_d;
						dims_q       <= dims_sat;
						row_q        <= '0;
						d_q          <= '0;
						acc_q        <= '0;
						if (count_q == '0) begin
							out_busy_q <= 1'b1;
							emit_k_q   <= '0;
							state_q    <= ST_IDLE;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					if (issue_fire) begin
						d_q <= d_q + DIMS_CNT_W'(1);
					end
					if (v_s3) begin
						acc_q <= acc_q + ACC_W'(sq_s3);
					end
					if (drained) begin
						sq_x_q    <= acc_q;
						sq_rem_q  <= '0;
						sq_root_q <= '0;
						sq_cnt_q  <= '0;
						state_q   <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					sq_x_q    <= sq_x_q << 2;
					sq_rem_q  <= rem_nxt;
					sq_root_q <= root_nxt;
					sq_cnt_q  <= sq_cnt_q + SQ_CNT_W'(1);
					if (sq_cnt_q == SQ_CNT_W'(SQRT_STEPS - 1)) begin
						cd_q    <= root_nxt;
						cr_q    <= row_q;
						cv_q    <= 1'b1;
						k_q     <= '0;
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					// candidate swaps with the slot, the displaced entry carries on
					if (swap) begin
						best_dist_q[k_q]  <= cd_q;
						best_row_q[k_q]   <= cr_q;
						best_valid_q[k_q] <= 1'b1;
						cd_q              <= best_dist_q[k_q];
						cr_q              <= best_row_q[k_q];
						cv_q              <= best_valid_q[k_q];
					end
					if (k_q == nm1_q) begin
						if (row_last) begin
							out_busy_q <= 1'b1;
							emit_k_q   <= '0;
							state_q    <= ST_IDLE;
						end else begin
							row_q   <= row_q + ROW_W'(1);
							d_q     <= '0;
							acc_q   <= '0;
							state_q <= ST_ISSUE;
						end
					end else begin
						k_q <= k_q + BEST_IW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result fields, empty slots read as zero
	assign sel_valid = best_valid_q[emit_k_q];
	assign m_tvalid  = out_busy_q;
	assign m_tuser   = sel_valid;
	assign m_tlast   = (emit_k_q == nm1_q);
	assign m_tdata   = {{M_PAD_W{1'b0}},
		(sel_valid ? best_dist_q[emit_k_q] : {DIST_W{1'b0}}),
		(sel_valid ? best_row_q[emit_k_q] : {ROW_W{1'b0}}),
		RANK_W'(emit_k_q)};

	// terms for the checks
	assign scanning = (state_q == ST_ISSUE) || (state_q == ST_SQRT) || (state_q == ST_INSERT);
	assign out_xfer = m_tvalid && m_tready;

	// checks
	`KBDM_ASSERT(a_no_scan_drain, clk, arst_n, !(out_busy_q && scanning), "scan during drain")
	`KBDM_ASSERT(a_d_in_range, clk, arst_n, (state_q != ST_ISSUE) || (d_q <= dims_q), "row overrun")
	`KBDM_ASSERT(a_emit_in_range, clk, arst_n, !out_busy_q || (emit_k_q <= nm1_q), "rank overrun")
	`KBDM_ASSERT_NEXT(a_drain_ends, clk, arst_n, out_xfer && m_tlast, !m_tvalid, "extra result")

endmodule

[bench/kbdm_match_checker.sv]
module kbdm_match_checker
	import kbdm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // row, dim, value, ref_count
	input  logic [FUNC_W-1:0]    s_tuser,   // func
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_DATA_W-1:0]  m_tdata,   // rank, match_index, distance, zero pad
	input  logic                 m_tuser,   // found
	input  logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   errors,
	output int                   pending,
	output int                   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [RANK_W-1:0] rank;
		logic [ROW_W-1:0]  row;
		logic [DIST_W-1:0] distance;
		logic              found;
		logic              last;
	} match_t;

	// predicted matches, oldest first
	match_t match_q[$];

	// shadow copies of the descriptor stores and the registers
	logic signed [VAL_W-1:0] ref_mem [MAX_REF_ROWS][MAX_DIMS];
	logic signed [VAL_W-1:0] qry_mem [MAX_DIMS];
	logic [BC_W-1:0]         best_count;
	logic [DU_W-1:0]         dims_in_use;

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
	end

	// one line per mismatch
	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// floor square root, one result bit per step
	function automatic logic [DIST_W-1:0] floor_sqrt(input longint unsigned x);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'h1 << 62;
		while (probe > x)
			probe >>= 2;
		while (probe != 0) begin
			if (x >= root + probe) begin
				x -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root[DIST_W-1:0];
	endfunction

	// scan rows, keep the n nearest in order, queue one result per rank
	function automatic void predict_search(input logic [CNT_W-1:0] count_field);
		int unsigned       n, dims, rows, r, d, k;
		logic [DIST_W-1:0] bd [MAX_BEST];
		logic [ROW_W-1:0]  br [MAX_BEST];
		bit                bv [MAX_BEST];
		logic [DIST_W-1:0] cd, td;
		logic [ROW_W-1:0]  cr, tr;
		bit                cv, tv;
		longint unsigned   acc;
		longint            diff;
		match_t            m;
		n = (best_count == 0) ? 1 : best_count;
		if (n > MAX_BEST)
			n = MAX_BEST;
		dims = (dims_in_use > MAX_DIMS) ? MAX_DIMS : dims_in_use;
		rows = (count_field > MAX_REF_ROWS) ? MAX_REF_ROWS : count_field;
		for (k = 0; k < MAX_BEST; k++) begin
			bd[k] = '0;
			br[k] = '0;
			bv[k] = 1'b0;
		end
		for (r = 0; r < rows; r++) begin
			acc = 0;
			for (d = 0; d < dims; d++) begin
				diff = longint'(qry_mem[d]) - longint'(ref_mem[r][d]);
				acc += diff * diff;
			end
			cd = floor_sqrt(acc);
			cr = r[ROW_W-1:0];
			cv = 1'b1;
			// strict less-than: a tie keeps the earlier row ahead
			for (k = 0; k < n; k++) begin
				if (cv && (!bv[k] || cd < bd[k])) begin
					td = bd[k];
					tr = br[k];
					tv = bv[k];
					bd[k] = cd;
					br[k] = cr;
					bv[k] = 1'b1;
					cd = td;
					cr = tr;
					cv = tv;
				end
			end
		end
		for (k = 0; k < n; k++) begin
			m.rank = k[RANK_W-1:0];
			m.row = bv[k] ? br[k] : '0;
			m.distance = bv[k] ? bd[k] : '0;
			m.found = bv[k];
			m.last = (k + 1 == n);
			match_q.push_back(m);
		end
	endfunction

	// compare one result transfer with the oldest prediction
	task automatic check_result();
		match_t            want;
		logic [RANK_W-1:0] got_rank;
		logic [ROW_W-1:0]  got_row;
		logic [DIST_W-1:0] got_dist;
		got_rank = m_tdata[RANK_W-1:0];
		got_row = m_tdata[RANK_W +: ROW_W];
		got_dist = m_tdata[RANK_W + ROW_W +: DIST_W];
		if (match_q.size() == 0) begin
			report($sformatf("result transfer rank %0d with no search result waiting",
				got_rank));
		end else begin
			want = match_q.pop_front();
			checked++;
			if (got_rank !== want.rank)
				report($sformatf("rank got %0d want %0d", got_rank, want.rank));
			if (got_row !== want.row)
				report($sformatf("rank %0d: match_index got %0d want %0d",
					want.rank, got_row, want.row));
			if (got_dist !== want.distance)
				report($sformatf("rank %0d: distance got %0d want %0d",
					want.rank, got_dist, want.distance));
			if (m_tuser !== want.found)
				report($sformatf("rank %0d: found got %b want %b",
					want.rank, m_tuser, want.found));
			if (m_tlast !== want.last)
				report($sformatf("rank %0d: last got %b want %b",
					want.rank, m_tlast, want.last));
		end
	endtask

	// follow every transfer and register write in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_count = BEST_COUNT_RST;
			dims_in_use = DIMS_IN_USE_RST;
			match_q.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					FUNC_LOAD_REF: begin
						ref_mem[s_tdata[IN_ROW_LSB +: ROW_W]][s_tdata[IN_DIM_LSB +: DIM_W]] =
							s_tdata[IN_VAL_LSB +: VAL_W];
					end
					FUNC_LOAD_QRY: begin
						qry_mem[s_tdata[IN_DIM_LSB +: DIM_W]] = s_tdata[IN_VAL_LSB +: VAL_W];
					end
					FUNC_RUN: begin
						predict_search(s_tdata[IN_CNT_LSB +: CNT_W]);
					end
					default: ;
				endcase
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_BEST_COUNT:  best_count = cfg_wdata[BC_W-1:0];
					CFG_DIMS_IN_USE: dims_in_use = cfg_wdata[DU_W-1:0];
					default: ;
				endcase
			end
		end
		pending = match_q.size();
	end

endmodule

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kbdm_pkg::*;

	localparam int GAP_MAX     = 14;
	localparam int SETTLE      = 40;
	localparam int LIMIT       = 200000;
	localparam int ITEM_TARGET = 470;
	localparam int NUM_PHASES  = 10;
	localparam int CNT_TOP     = (1 << CNT_W) - 1;

	// func code the block ignores
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// register settings swept by the random part
	localparam logic [CFG_W-1:0] PHASE_BC [NUM_PHASES] =
		'{8'h02, 8'h0C, 8'hF5, 8'h00, 8'h08, 8'h07, 8'h01, 8'h06, 8'hA3, 8'h08};
	localparam logic [CFG_W-1:0] PHASE_DU [NUM_PHASES] =
		'{8'h01, 8'h00, 8'hFF, 8'h04, 8'h02, 8'h80, 8'h03, 8'h10, 8'h08, 8'h81};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;   // row, dim, value, ref_count
	logic [FUNC_W-1:0]    s_tuser = '0;   // func
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;        // rank, match_index, distance, zero pad
	logic                 m_tuser;        // found
	logic                 m_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	int errors;
	int pending;
	int checked;

	// which store entries hold data, so a search never reads an empty one
	bit          ref_written [MAX_REF_ROWS][MAX_DIMS];
	bit          qry_written [MAX_DIMS];
	int unsigned dims_eff = MAX_DIMS;
	bit          no_gaps = 1'b0;
	int unsigned items = 0;
	int unsigned searches = 0;
	int unsigned settings = 0;
	int unsigned stall_cycles = 0;

	k_best_descriptor_matcher_core dut (.*);

	kbdm_match_checker u_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on cycles without any transfer or register write
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random back-pressure before each transfer
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// one input transfer, entered and left at a falling edge
	task automatic send(input logic [FUNC_W-1:0] func, input logic [ROW_W-1:0] row,
		input logic [DIM_W-1:0] dim, input logic [VAL_W-1:0] val,
		input logic [CNT_W-1:0] cnt);
		int unsigned         gap;
		logic [S_DATA_W-1:0] word;
		gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		word = '0;
		word[IN_ROW_LSB +: ROW_W] = row;
		word[IN_DIM_LSB +: DIM_W] = dim;
		word[IN_VAL_LSB +: VAL_W] = val;
		word[IN_CNT_LSB +: CNT_W] = cnt;
		s_tdata <= word;
		s_tuser <= func;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (func == FUNC_LOAD_REF)
			ref_written[row][dim] = 1'b1;
		if (func == FUNC_LOAD_QRY)
			qry_written[dim] = 1'b1;
		if (func == FUNC_RUN)
			searches++;
		items++;
	endtask

	// wait until every result is out and the block is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] bc, input logic [CFG_W-1:0] du);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_BEST_COUNT;
		cfg_wdata <= bc;
		@(negedge clk);
		cfg_index <= CFG_DIMS_IN_USE;
		cfg_wdata <= du;
		@(negedge clk);
		cfg_we <= 1'b0;
		dims_eff = (du > MAX_DIMS) ? MAX_DIMS : du;
		settings++;
	endtask

	// full range, extremes, or a narrow band that makes ties
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return VAL_W'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					default: return 16'h0000;
				endcase
			end
			default: return VAL_W'(int'($urandom_range(0, 6)) - 3);
		endcase
	endfunction

	// row count for a search, kept small when many elements are compared
	function automatic int unsigned pick_count(input bit first);
		int unsigned lim;
		if (dims_eff == 0 && (first || $urandom_range(0, 9) == 0))
			return $urandom_range(MAX_REF_ROWS, CNT_TOP);
		if ($urandom_range(0, 9) == 0)
			return 0;
		lim = (dims_eff <= 2) ? 24 : ((dims_eff >= 32) ? 1 : 32 / dims_eff);
		return $urandom_range(1, lim);
	endfunction

	// fill whatever the search will read, stir the data a little, then search
	task automatic search(input int unsigned cnt);
		int unsigned rows, r, d, k, extra;
		rows = (cnt > MAX_REF_ROWS) ? MAX_REF_ROWS : cnt;
		for (d = 0; d < dims_eff; d++)
			if (!qry_written[d])
				send(FUNC_LOAD_QRY, ROW_W'($urandom), DIM_W'(d), pick_value(),
					CNT_W'($urandom));
		for (r = 0; r < rows; r++)
			for (d = 0; d < dims_eff; d++)
				if (!ref_written[r][d])
					send(FUNC_LOAD_REF, ROW_W'(r), DIM_W'(d), pick_value(),
						CNT_W'($urandom));
		extra = $urandom_range(0, 5);
		for (k = 0; k < extra; k++) begin
			case ($urandom_range(0, 5))
				0: send(FUNC_UNUSED, ROW_W'($urandom), DIM_W'($urandom), VAL_W'($urandom),
					CNT_W'($urandom));
				1: send(FUNC_LOAD_REF, ROW_W'($urandom), DIM_W'($urandom), pick_value(),
					CNT_W'($urandom));
				2: begin
					if (dims_eff != 0)
						send(FUNC_LOAD_QRY, ROW_W'($urandom),
							DIM_W'($urandom_range(0, dims_eff - 1)),
							pick_value(), CNT_W'($urandom));
				end
				default: begin
					if (rows != 0 && dims_eff != 0)
						send(FUNC_LOAD_REF, ROW_W'($urandom_range(0, rows - 1)),
							DIM_W'($urandom_range(0, dims_eff - 1)), pick_value(),
							CNT_W'($urandom));
				end
			endcase
		end
		send(FUNC_RUN, ROW_W'($urandom), DIM_W'($urandom), VAL_W'($urandom), CNT_W'(cnt));
	endtask

	// stimulus and verdict
	initial begin
		int unsigned p, k, runs;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: ignored func, empty search
		send(FUNC_UNUSED, 8'hFF, 7'h7F, 16'hFFFF, 9'h1FF);
		send(FUNC_RUN, 8'h00, 7'h00, 16'h0000, 9'd0);

		// oversized best count, no elements compared: all ties, earlier rows first
		set_config(8'hFF, 8'h00);
		send(FUNC_RUN, 8'hFF, 7'h7F, 16'hFFFF, 9'd5);
		send(FUNC_RUN, 8'h00, 7'h00, 16'h0000, 9'h1FF);

		// best count zero acts as one; largest element differences
		set_config(8'h00, 8'h01);
		send(FUNC_LOAD_QRY, 8'h00, 7'd0, 16'h8000, 9'd0);
		send(FUNC_LOAD_REF, 8'd0, 7'd0, 16'h7FFF, 9'd0);
		send(FUNC_LOAD_REF, 8'd1, 7'd0, 16'h8000, 9'd0);
		send(FUNC_LOAD_REF, 8'd2, 7'd0, 16'h0000, 9'd0);
		send(FUNC_LOAD_REF, 8'd3, 7'd0, 16'h7FFF, 9'd0);
		send(FUNC_RUN, 8'h00, 7'h00, 16'h0000, 9'd4);

		// two elements: drop from a full list, then a list with an empty slot
		set_config(8'h03, 8'h02);
		send(FUNC_LOAD_QRY, 8'h00, 7'd1, 16'h7FFF, 9'd0);
		send(FUNC_LOAD_REF, 8'd0, 7'd1, 16'h8000, 9'd0);
		send(FUNC_LOAD_REF, 8'd1, 7'd1, 16'h7FFF, 9'd0);
		send(FUNC_LOAD_REF, 8'd2, 7'd1, 16'h0000, 9'd0);
		send(FUNC_LOAD_REF, 8'd3, 7'd1, 16'hFFFF, 9'd0);
		send(FUNC_RUN, 8'h00, 7'h00, 16'h0000, 9'd4);
		send(FUNC_RUN, 8'h00, 7'h00, 16'h0000, 9'd2);

		// random searches over a sweep of register settings
		for (p = 0; p < NUM_PHASES || items < ITEM_TARGET; p++) begin
			set_config(PHASE_BC[p % NUM_PHASES], PHASE_DU[p % NUM_PHASES]);
			no_gaps = ($urandom_range(0, 3) == 0);
			runs = $urandom_range(3, 5);
			for (k = 0; k < runs; k++)
				search(pick_count(k == 0));
		end

		settle();
		$display("covered %0d input transfers, %0d of them searches, over %0d register settings",
			items, searches, settings);
		$display("%0d results compared, %0d mismatches", checked, errors);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/kbdm_pkg.sv
src/kbdm_ram.sv
src/k_best_descriptor_matcher_core.sv
bench/kbdm_match_checker.sv
bench/tb_top.sv
